[rtl/pab_pkg.sv]
// ----------------------------------------------------------------------------
// pab_pkg: shared types and constants for the partial amplitude blender
// Beat layouts for both channels, blend mode codes and register indexes.
// ----------------------------------------------------------------------------
package pab_pkg;

   localparam int AMP_W    = 16;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 7;
   localparam int MODE_W   = 3;
   localparam int GAIN_W   = 17;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // blend modes
   localparam logic [MODE_W-1:0] MODE_FADE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MAXIMUM  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MINIMUM  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PLUCK    = 3'd5;

   // register indexes (word address)
   localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
   localparam logic [1:0] REG_MIX_AMOUNT  = 2'd1;
   localparam logic [1:0] REG_PLUCK_RATIO = 2'd2;

   // reset values
   localparam logic [MODE_W-1:0] BLEND_MODE_RST  = MODE_FADE;
   localparam logic [AMP_W-1:0]  MIX_AMOUNT_RST  = 16'd16384;
   localparam logic [AMP_W-1:0]  PLUCK_RATIO_RST = 16'd65521;
   localparam logic [GAIN_W-1:0] GAIN_ONE        = 17'd65536;
   localparam logic [AMP_W-1:0]  Q15_ONE         = 16'd32768;
   localparam logic [AMP_W-1:0]  AMP_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [AMP_W-1:0]   amp_first;
      logic [AMP_W-1:0]   amp_second;
      logic [WORD_W-1:0]  freq_word;
      logic [WORD_W-1:0]  phase_word;
      logic [COUNT_W-1:0] active_first;
      logic [COUNT_W-1:0] active_second;
      logic               last_partial;
   } req_payload_type;

   typedef struct packed {
      logic [AMP_W-1:0]   blended_amp;
      logic [WORD_W-1:0]  freq_out;
      logic [WORD_W-1:0]  phase_out;
      logic [COUNT_W-1:0] active_out;
      logic               frame_end;
   } rsp_payload_type;

endpackage

[rtl/partial_amplitude_blender.sv]
// ----------------------------------------------------------------------------
// partial_amplitude_blender: blends two timbres' partial amplitudes
// Sequence: a beat accepted in idle runs through MUL_A, MUL_B, MUL_G, MUL_R
//    and DONE, and DONE registers its result beat; an output stall holds the
//    last step until it drains. A new beat is taken only back in idle, after
//    four passes through the one shared 32x17 multiplier and the finish step.
// Reset (synchronous): registers back to defaults, decay gain to one,
//    both channels empty.
// ----------------------------------------------------------------------------
module partial_amplitude_blender (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pab_pkg::req_payload_type    req_payload,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pab_pkg::rsp_payload_type    rsp_payload,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pab_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [pab_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [pab_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   // Sequencer steps. Each busy step issues one multiply into prod_ff; from
   // MUL_B on, a step may fold the previous product into acc_ff.
   //   MUL_A : a*om (or a*b for multiply mode)
   //   MUL_B : b*m            acc <= a*om
   //   MUL_G : (b*m)*g        fade: acc += b*m
   //   MUL_R : g*ratio        pluck: acc <= (a*om << 16) + b*m*g
   //   DONE  : round/saturate, load result beat, step decay gain
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_G,
      ST_MUL_R,
      ST_DONE
   } state_type;

   localparam int PROD_W = 49;
   localparam int ACC_W  = 50;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [pab_pkg::MODE_W-1:0] blend_mode_ff;
   logic [pab_pkg::AMP_W-1:0]  mix_amount_ff;
   logic [pab_pkg::AMP_W-1:0]  pluck_ratio_ff;

   logic csr_write;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff  <= pab_pkg::BLEND_MODE_RST;
         mix_amount_ff  <= pab_pkg::MIX_AMOUNT_RST;
         pluck_ratio_ff <= pab_pkg::PLUCK_RATIO_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            pab_pkg::REG_BLEND_MODE:  blend_mode_ff  <= csr_pwdata[pab_pkg::MODE_W-1:0];
            pab_pkg::REG_MIX_AMOUNT:  mix_amount_ff  <= csr_pwdata[pab_pkg::AMP_W-1:0];
            pab_pkg::REG_PLUCK_RATIO: pluck_ratio_ff <= csr_pwdata[pab_pkg::AMP_W-1:0];
            default: ;  // unmapped word: dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         pab_pkg::REG_BLEND_MODE:  csr_prdata = {29'd0, blend_mode_ff};
         pab_pkg::REG_MIX_AMOUNT:  csr_prdata = {16'd0, mix_amount_ff};
         pab_pkg::REG_PLUCK_RATIO: csr_prdata = {16'd0, pluck_ratio_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // mix clamped to one, and its complement
   logic [pab_pkg::AMP_W-1:0] mix_q15;
   logic [pab_pkg::AMP_W-1:0] mix_inv;
   assign mix_q15 = (mix_amount_ff > pab_pkg::Q15_ONE) ? pab_pkg::Q15_ONE : mix_amount_ff;
   assign mix_inv = pab_pkg::Q15_ONE - mix_q15;

   // ---------------------------------------------------------------------
   // Datapath state
   // ---------------------------------------------------------------------
   state_type                  state_ff, state_in;
   pab_pkg::req_payload_type   item_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [pab_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic                       rsp_valid_ff;
   pab_pkg::rsp_payload_type   rsp_ff, rsp_in;

   logic req_take;
   logic finish;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // shared multiplier operand select
   logic [31:0]               mul_a;
   logic [16:0]               mul_b;
   logic [PROD_W-1:0]         mul_p;

   always_comb begin
      case (state_ff)
         ST_MUL_A: begin
            mul_a = {16'd0, item_ff.amp_first};
            mul_b = (blend_mode_ff == pab_pkg::MODE_MULTIPLY) ?
                    {1'b0, item_ff.amp_second} : {1'b0, mix_inv};
         end
         ST_MUL_B: begin
            mul_a = {16'd0, item_ff.amp_second};
            mul_b = {1'b0, mix_q15};
         end
         ST_MUL_G: begin
            mul_a = prod_ff[31:0];
            mul_b = gain_ff;
         end
         ST_MUL_R: begin
            mul_a = {15'd0, gain_ff};
            mul_b = {1'b0, pluck_ratio_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // accumulator: adders with selected operands per step
   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         ST_MUL_B: acc_in = {1'b0, prod_ff};
         ST_MUL_G: begin
            if (blend_mode_ff == pab_pkg::MODE_FADE) begin
               acc_in = acc_ff + {1'b0, prod_ff};
            end
         end
         ST_MUL_R: begin
            if (blend_mode_ff == pab_pkg::MODE_PLUCK) begin
               acc_in = {acc_ff[33:0], 16'd0} + {1'b0, prod_ff};
            end
         end
         default: ;
      endcase
   end

   // finish step: rounding, saturation, simple modes
   logic [ACC_W-1:0]          q15_sum;
   logic [ACC_W-1:0]          q31_sum;
   logic [pab_pkg::AMP_W-1:0] q15_amp;
   logic [pab_pkg::AMP_W-1:0] q31_amp;
   logic [pab_pkg::AMP_W-1:0] amp_a, amp_b;
   logic [pab_pkg::AMP_W-1:0] blend;
   logic [PROD_W-1:0]         gain_rnd;

   assign amp_a   = item_ff.amp_first;
   assign amp_b   = item_ff.amp_second;
   assign q15_sum = acc_ff + ACC_W'(1 << 14);
   assign q31_sum = acc_ff + ACC_W'(1 << 30);
   assign q15_amp = (|q15_sum[ACC_W-1:31]) ? pab_pkg::AMP_MAX : q15_sum[30:15];
   assign q31_amp = (|q31_sum[ACC_W-1:47]) ? pab_pkg::AMP_MAX : q31_sum[46:31];
   assign gain_rnd = prod_ff + PROD_W'(1 << 15);

   always_comb begin
      case (blend_mode_ff)
         pab_pkg::MODE_FADE:     blend = q15_amp;
         pab_pkg::MODE_MULTIPLY: blend = q15_amp;
         pab_pkg::MODE_PLUCK:    blend = q31_amp;
         pab_pkg::MODE_SUBTRACT: blend = (amp_a > amp_b) ? (amp_a - amp_b) : '0;
         pab_pkg::MODE_MAXIMUM:  blend = (amp_a > amp_b) ? amp_a : amp_b;
         pab_pkg::MODE_MINIMUM:  blend = (amp_a < amp_b) ? amp_a : amp_b;
         default:                blend = '0;  // unused mode codes
      endcase
   end

   always_comb begin
      rsp_in.blended_amp = blend;
      rsp_in.freq_out    = item_ff.freq_word;
      rsp_in.phase_out   = item_ff.phase_word;
      rsp_in.active_out  = (item_ff.active_first > item_ff.active_second) ?
                           item_ff.active_first : item_ff.active_second;
      rsp_in.frame_end   = item_ff.last_partial;
   end

   // gain restarts at one after the frame's last partial, else decays
   assign gain_in = item_ff.last_partial ? pab_pkg::GAIN_ONE : gain_rnd[32:16];

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = req_take ? ST_MUL_A : ST_IDLE;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_MUL_G;
         ST_MUL_G: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_DONE;
         ST_DONE:  state_in = finish ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= pab_pkg::GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            item_ff <= req_payload;
         end
         if (state_ff != ST_IDLE && state_ff != ST_DONE) begin
            prod_ff <= mul_p;
            acc_ff  <= acc_in;
         end
         if (finish) begin
            gain_ff      <= gain_in;
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= pab_pkg::GAIN_ONE)
      else $error("decay gain above one");

   a_gain_restart: assert property (@(posedge clock) disable iff (reset)
      finish && item_ff.last_partial |=> gain_ff == pab_pkg::GAIN_ONE)
      else $error("decay gain not restarted after frame end");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside finish step");

   a_take_to_done: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ##3 state_ff == ST_MUL_R)
      else $error("sequencer skipped a multiply step");

endmodule
